### hdl/integer_token_parser_si_suffix_assert.svh
// Assertion macros used by the checker file.
`ifndef INTEGER_TOKEN_PARSER_SI_SUFFIX_ASSERT_SVH
`define INTEGER_TOKEN_PARSER_SI_SUFFIX_ASSERT_SVH

// General property, clocked and disabled while reset is low.
`define ITP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition implies that a signal keeps its value into the next cycle.
`define ITP_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

### hdl/itp_pkg.sv
`timescale 1ns / 1ps

package itp_pkg;

    // Default queue depths (two entries keep one item per cycle flowing)
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF   = 2;

    // Character codes
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_Z_UP = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_K    = 8'h6B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    // Suffix scaling and fraction digit budgets
    localparam logic [31:0] SCALE_K  = 32'd1000;
    localparam logic [31:0] SCALE_M  = 32'd1000000;
    localparam logic [2:0]  DIGITS_K = 3'd3;
    localparam logic [2:0]  DIGITS_M = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEADZERO,
        PH_DEC,
        PH_HEXSTART,
        PH_HEX,
        PH_FRAC
    } t_phase;

    // Character class produced by the front end
    typedef struct packed {
        logic       is_dec;
        logic       is_hex;
        logic       is_prefix;
        logic       suf_k;
        logic       suf_m;
        logic [3:0] nib;
    } t_cls;

    // One parse result
    typedef struct packed {
        logic [31:0] value;
        logic        ok;
        logic        hex;
    } t_result;

    // Weight of the next fraction digit, given the digits still allowed
    function automatic logic [19:0] frac_place(input logic [2:0] left);
        logic [19:0] place;
        case (left)
            3'd1:    place = 20'd1;
            3'd2:    place = 20'd10;
            3'd3:    place = 20'd100;
            3'd4:    place = 20'd1000;
            3'd5:    place = 20'd10000;
            3'd6:    place = 20'd100000;
            default: place = 20'd0;
        endcase
        return place;
    endfunction

endpackage

### hdl/itp_fifo.sv
`timescale 1ns / 1ps

module itp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/itp_front.sv
`timescale 1ns / 1ps

module itp_front (
    input  logic [7:0]   i_char,
    output itp_pkg::t_cls o_cls
);

    logic [7:0] w_lower;
    logic [7:0] w_dec_ofs;
    logic [7:0] w_hex_ofs;
    logic       w_is_dec;
    logic       w_is_letter;

    // Fold upper case letters to lower case
    always_comb begin
        if (i_char inside {[itp_pkg::CH_A_UP:itp_pkg::CH_Z_UP]}) begin
            w_lower = i_char + itp_pkg::CASE_OFS;
        end else begin
            w_lower = i_char;
        end
    end

    // Classify the character
    always_comb begin
        w_is_dec    = i_char inside {[itp_pkg::CH_0:itp_pkg::CH_9]};
        w_is_letter = w_lower inside {[itp_pkg::CH_A:itp_pkg::CH_F]};
        w_dec_ofs   = i_char - itp_pkg::CH_0;
        w_hex_ofs   = w_lower - itp_pkg::CH_A + itp_pkg::HEX_LETTER_BASE;

        o_cls.is_dec    = w_is_dec;
        o_cls.is_hex    = w_is_dec || w_is_letter;
        o_cls.is_prefix = (w_lower == itp_pkg::CH_X) || (w_lower == itp_pkg::CH_H);
        o_cls.suf_k     = (w_lower == itp_pkg::CH_K);
        o_cls.suf_m     = (w_lower == itp_pkg::CH_M);
        o_cls.nib       = w_is_dec ? w_dec_ofs[3:0] : w_hex_ofs[3:0];
    end

endmodule

### hdl/itp_back.sv
`timescale 1ns / 1ps

module itp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  itp_pkg::t_cls     i_cls,
    output logic              o_take,
    input  logic              i_out_full,
    output logic              o_res_push,
    output itp_pkg::t_result  o_res
);

    itp_pkg::t_phase r_phase, n_phase;
    logic [31:0]     r_acc, n_acc;
    logic [2:0]      r_left, n_left;

    logic        w_step;
    logic        w_suffix;
    logic [31:0] w_scale;
    logic [31:0] w_scaled;
    logic [31:0] w_dec_next;
    logic [31:0] w_hex_next;
    logic [23:0] w_frac_term;
    logic [2:0]  w_digits;

    assign w_step = i_valid && !i_out_full;
    assign o_take = w_step;

    // Datapath terms
    assign w_suffix    = i_cls.suf_k || i_cls.suf_m;
    assign w_scale     = i_cls.suf_m ? itp_pkg::SCALE_M : itp_pkg::SCALE_K;
    assign w_digits    = i_cls.suf_m ? itp_pkg::DIGITS_M : itp_pkg::DIGITS_K;
    assign w_scaled    = r_acc * w_scale;
    assign w_dec_next  = (r_acc << 3) + (r_acc << 1) + 32'(i_cls.nib);
    assign w_hex_next  = {r_acc[27:0], i_cls.nib};
    assign w_frac_term = 24'(i_cls.nib) * 24'(itp_pkg::frac_place(r_left));

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_step) begin
            case (r_phase)
                itp_pkg::PH_IDLE: begin
                    if (i_cls.is_dec) begin
                        n_phase = (i_cls.nib == 4'd0) ? itp_pkg::PH_LEADZERO : itp_pkg::PH_DEC;
                    end else if (i_cls.is_prefix) begin
                        n_phase = itp_pkg::PH_HEXSTART;
                    end else begin
                        n_phase = itp_pkg::PH_IDLE;
                    end
                end
                itp_pkg::PH_LEADZERO, itp_pkg::PH_DEC: begin
                    if (r_phase == itp_pkg::PH_LEADZERO && i_cls.is_prefix) begin
                        n_phase = itp_pkg::PH_HEXSTART;
                    end else if (i_cls.is_dec) begin
                        n_phase = itp_pkg::PH_DEC;
                    end else if (w_suffix) begin
                        n_phase = itp_pkg::PH_FRAC;
                    end else begin
                        n_phase = itp_pkg::PH_IDLE;
                    end
                end
                itp_pkg::PH_HEXSTART, itp_pkg::PH_HEX: begin
                    n_phase = i_cls.is_hex ? itp_pkg::PH_HEX : itp_pkg::PH_IDLE;
                end
                itp_pkg::PH_FRAC: begin
                    n_phase = i_cls.is_dec ? itp_pkg::PH_FRAC : itp_pkg::PH_IDLE;
                end
                default: n_phase = itp_pkg::PH_IDLE;
            endcase
        end
    end

    // Accumulator, fraction budget and result
    always_comb begin
        n_acc       = r_acc;
        n_left      = r_left;
        o_res_push  = 1'b0;
        o_res.value = r_acc;
        o_res.ok    = 1'b1;
        o_res.hex   = 1'b0;
        if (w_step) begin
            case (r_phase)
                itp_pkg::PH_IDLE: begin
                    if (i_cls.is_dec) begin
                        n_acc = 32'(i_cls.nib);
                    end else if (i_cls.is_prefix) begin
                        n_acc = '0;
                    end else begin
                        o_res_push  = 1'b1;
                        o_res.value = '0;
                        o_res.ok    = 1'b0;
                    end
                end
                itp_pkg::PH_LEADZERO, itp_pkg::PH_DEC: begin
                    if (r_phase == itp_pkg::PH_LEADZERO && i_cls.is_prefix) begin
                        n_acc = '0;
                    end else if (i_cls.is_dec) begin
                        n_acc = w_dec_next;
                    end else if (w_suffix) begin
                        n_acc  = w_scaled;
                        n_left = w_digits;
                    end else begin
                        o_res_push = 1'b1;
                    end
                end
                itp_pkg::PH_HEXSTART: begin
                    if (i_cls.is_hex) begin
                        n_acc = 32'(i_cls.nib);
                    end else begin
                        o_res_push  = 1'b1;
                        o_res.value = '0;
                        o_res.ok    = 1'b0;
                        o_res.hex   = 1'b1;
                    end
                end
                itp_pkg::PH_HEX: begin
                    if (i_cls.is_hex) begin
                        n_acc = w_hex_next;
                    end else begin
                        o_res_push = 1'b1;
                        o_res.hex  = 1'b1;
                    end
                end
                itp_pkg::PH_FRAC: begin
                    // fraction digits land directly at their decimal weight
                    if (i_cls.is_dec) begin
                        if (r_left != 3'd0) begin
                            n_acc  = r_acc + 32'(w_frac_term);
                            n_left = r_left - 3'd1;
                        end
                    end else begin
                        o_res_push = 1'b1;
                    end
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= itp_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_left <= n_left;
    end

endmodule

### hdl/integer_token_parser_si_suffix.sv
// Streaming parser for unsigned 32-bit integer tokens, one ASCII character per item.
// A token is hex after an optional '0' and an 'x' or 'h' prefix (any case), else decimal
// with an optional 'k'/'m' suffix and up to 3/6 zero-padded fraction digits; values wrap
// modulo 2^32. The first character that does not fit ends the token and yields one result
// (value, ok flag, hex flag); a bad first character gives a failure result. One character
// is taken every cycle while full is low: the parser advances one character per cycle while
// the result queue has room, its longest step being the multiply by 10^3 or 10^6 when a
// suffix arrives. A result becomes visible after its terminating character is accepted: the
// character waits in the character queue, the parser steps on it and writes the result queue,
// and a full result queue can hold it back. Both queues let either side stall on its own.
`timescale 1ns / 1ps

module integer_token_parser_si_suffix #(
    parameter int QUEUE_DEPTH = itp_pkg::QUEUE_DEPTH_DEF,
    parameter int OUT_DEPTH   = itp_pkg::OUT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic [7:0]  i_char_in,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] o_parsed_value,
    output logic        o_parse_ok,
    output logic        o_was_hex
);

    itp_pkg::t_cls    w_cls_in, w_cls_q;
    itp_pkg::t_result w_res_in, w_res_q;
    logic             w_q_empty, w_q_pop;
    logic             w_out_full, w_res_push;

    // Front: classify each character
    itp_front u_front (
        .i_char (i_char_in),
        .o_cls  (w_cls_in)
    );

    // Queue of classified characters
    itp_fifo #(
        .WIDTH ($bits(itp_pkg::t_cls)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cls_in),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_cls_q)
    );

    // Back: parser state machine
    itp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_q_empty),
        .i_cls      (w_cls_q),
        .o_take     (w_q_pop),
        .i_out_full (w_out_full),
        .o_res_push (w_res_push),
        .o_res      (w_res_in)
    );

    // Result queue
    itp_fifo #(
        .WIDTH ($bits(itp_pkg::t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_q)
    );

    assign o_parsed_value = w_res_q.value;
    assign o_parse_ok     = w_res_q.ok;
    assign o_was_hex      = w_res_q.hex;

endmodule

### hdl/itp_checker.sv
`timescale 1ns / 1ps
`include "integer_token_parser_si_suffix_assert.svh"

module itp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [31:0] o_parsed_value,
    input logic        o_parse_ok,
    input logic        o_was_hex
);

    logic       w_stall;
    logic       w_fail;
    logic [1:0] w_flags;

    assign w_stall = !empty && !pop;
    assign w_fail  = !empty && !o_parse_ok;
    assign w_flags = {o_parse_ok, o_was_hex};

    // A failed parse always reports zero
    `ITP_ASSERT(a_fail_zero, i_clk, i_rst_n, w_fail |-> (o_parsed_value == '0), "fail nonzero")

    // Input side fills only when items are pushed
    `ITP_ASSERT(a_full_push, i_clk, i_rst_n, $rose(full) |-> $past(push), "full without push")

    // A waiting result stays put until taken
    `ITP_ASSERT(a_stall_valid, i_clk, i_rst_n, w_stall |=> !empty, "waiting result vanished")
    `ITP_ASSERT_HOLD(a_stall_value, i_clk, i_rst_n, w_stall, o_parsed_value, "value changed")
    `ITP_ASSERT_HOLD(a_stall_flags, i_clk, i_rst_n, w_stall, w_flags, "flags changed")

endmodule

bind integer_token_parser_si_suffix itp_checker u_itp_checker (.*);
